// ===== rtl/core/ipban_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ipban_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = IDX_W + 1;

    localparam logic [31:0] MASK24 = 32'hFFFF_FF00;
    localparam logic [31:0] MASK16 = 32'hFFFF_0000;
    localparam logic [30:0] PERMANENT = 31'h7FFF_FFFF;
    localparam logic [5:0] SECS_PER_MIN = 6'd60;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_LOOKUP_IP = 3'd1,
        OP_LOOKUP_KEY = 3'd2,
        OP_LOOKUP_ID = 3'd3,
        OP_PURGE = 3'd4
    } opcode_t;

    typedef struct packed {
        logic [3:0] flags;
        logic [31:0] address;
        logic [31:0] key;
        logic [30:0] start;
        logic [30:0] penalty;
        logic [3:0] why;
        logic [31:0] stamp;
    } entry_t;

    typedef struct packed {
        logic ins_match;
        logic lk_match;
        logic expired;
        logic [31:0] age;
        logic [30:0] remaining;
    } eval_t;

endpackage

`default_nettype wire

// ===== rtl/core/ipban_eval.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipban_eval (
    input  ipban_pkg::entry_t row,
    input  logic [2:0]        op,
    input  logic [30:0]       now,
    input  logic [31:0]       ip_address,
    input  logic [31:0]       reg_key,
    input  logic [3:0]        ban_flags,
    input  logic [31:0]       default_counter,
    input  logic [31:0]       stamp_count,
    output ipban_pkg::eval_t  result
);
    import ipban_pkg::*;

    logic signed [33:0] left;
    logic live;
    logic addr_ok;
    logic key_ok;

    always_comb
    begin
        left = $signed({3'b000, row.penalty}) - $signed({3'b000, now})
             + $signed({3'b000, row.start});
        live = !left[33] && (left != 34'sd0);
        if (row.flags[1])
        begin
            addr_ok = (ip_address & MASK24) == (row.address & MASK24);
        end
        else if (row.flags[2])
        begin
            addr_ok = (ip_address & MASK16) == (row.address & MASK16);
        end
        else
        begin
            addr_ok = (ip_address == row.address)
                   && (row.key == 32'd0 || row.key == default_counter);
        end
        key_ok = (reg_key == row.key);
        result.lk_match = 1'b0;
        if (live && row.flags[0] == ban_flags[0])
        begin
            case (op)
                OP_LOOKUP_IP:  result.lk_match = addr_ok;
                OP_LOOKUP_KEY: result.lk_match = !row.flags[3] && key_ok;
                OP_LOOKUP_ID:  result.lk_match = row.flags[3] && key_ok;
                default:       result.lk_match = 1'b0;
            endcase
        end
        result.ins_match = (row.flags == ban_flags) && (row.address == ip_address)
                        && key_ok;
        result.expired = !live;
        result.age = stamp_count - row.stamp;
        result.remaining = (left > $signed({3'b000, PERMANENT})) ? PERMANENT : left[30:0];
    end

endmodule

`default_nettype wire

// ===== rtl/core/expiring_ip_ban_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ban table of 64 entries held in one synchronous memory. Every operation
// (insert, the three lookups and purge) reads all slots through the single
// memory read port, one slot per cycle. The next item is taken once the result
// is loaded into the output register, so no new item is taken while one is in
// work. Valid bits sit in flip-flops and are cleared by reset; no clearing pass
// is needed.
module expiring_ip_ban_table_unit (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [31:0]  cfg_wdata,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic [2:0]   opcode,
    input  wire logic [30:0]  now,
    input  wire logic [31:0]  ip_address,
    input  wire logic [31:0]  reg_key,
    input  wire logic [3:0]   ban_flags,
    input  wire logic [26:0]  penalty_minutes,
    input  wire logic [3:0]   reason,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              hit,
    output logic [5:0]        hit_index,
    output logic [3:0]        hit_reason,
    output logic [3:0]        hit_flags,
    output logic [31:0]       hit_ip,
    output logic [31:0]       hit_key,
    output logic [30:0]       hit_remaining,
    output logic [6:0]        purged_count,
    output logic              updated,
    output logic              dropped
);
    import ipban_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_WRITE = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    logic [31:0] default_counter_reg;
    logic [31:0] stamp_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [2:0] op_reg;
    logic [30:0] now_reg;
    logic [31:0] ip_reg;
    logic [31:0] key_reg;
    logic [3:0] flags_reg;
    logic [3:0] why_reg;
    logic [30:0] pen_reg;
    logic miss_reg;

    logic [CNT_W-1:0] scan_reg;
    logic eval_v_reg;
    logic [IDX_W-1:0] eval_idx_reg;

    logic best_found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0] best_age_reg;
    entry_t best_row_reg;
    logic [30:0] best_rem_reg;
    logic free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [6:0] count_reg;

    entry_t mem [ENTRIES];
    entry_t rd_data;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t mem_wdata;

    eval_t ev;
    logic [31:0] pen_prod;
    logic [30:0] pen_calc;
    logic issue;
    logic cand;
    logic better;
    logic row_valid;

    logic is_lookup;
    logic show_row;
    logic [5:0] hit_index_next;

    assign in_ready = (state_reg == S_IDLE);
    assign issue = (state_reg == S_SCAN) && (scan_reg < CNT_W'(ENTRIES));
    assign row_valid = valid_reg[eval_idx_reg];
    assign is_lookup = op_reg inside {OP_LOOKUP_IP, OP_LOOKUP_KEY, OP_LOOKUP_ID};
    assign show_row = is_lookup && best_found_reg;

    always_comb
    begin
        if (best_found_reg && (is_lookup || op_reg == OP_INSERT))
        begin
            hit_index_next = 6'(best_idx_reg);
        end
        else if (op_reg == OP_INSERT && free_found_reg)
        begin
            hit_index_next = 6'(free_idx_reg);
        end
        else
        begin
            hit_index_next = 6'd0;
        end
    end

    always_comb
    begin
        pen_prod = 32'(penalty_minutes[25:0]) * 32'(SECS_PER_MIN);
        if (penalty_minutes[26] || pen_prod > 32'(PERMANENT))
        begin
            pen_calc = PERMANENT;
        end
        else
        begin
            pen_calc = pen_prod[30:0];
        end
    end

    ipban_eval u_eval (
        .row(rd_data),
        .op(op_reg),
        .now(now_reg),
        .ip_address(ip_reg),
        .reg_key(key_reg),
        .ban_flags(flags_reg),
        .default_counter(default_counter_reg),
        .stamp_count(stamp_reg),
        .result(ev)
    );

    always_comb
    begin
        if (op_reg == OP_INSERT)
        begin
            cand = eval_v_reg && row_valid && ev.ins_match;
        end
        else
        begin
            cand = eval_v_reg && row_valid && ev.lk_match && !miss_reg;
        end
        better = cand && (!best_found_reg || ev.age < best_age_reg);
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_waddr = best_idx_reg;
        mem_wdata = best_row_reg;
        mem_wdata.start = now_reg;
        mem_wdata.penalty = pen_reg;
        mem_wdata.why = why_reg;
        if (state_reg == S_WRITE && op_reg == OP_INSERT)
        begin
            if (best_found_reg)
            begin
                mem_we = 1'b1;
            end
            else if (free_found_reg)
            begin
                mem_we = 1'b1;
                mem_waddr = free_idx_reg;
                mem_wdata.flags = flags_reg;
                mem_wdata.address = ip_reg;
                mem_wdata.key = key_reg;
                mem_wdata.stamp = stamp_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[scan_reg[IDX_W-1:0]];
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            op_reg <= opcode;
            now_reg <= now;
            ip_reg <= ip_address;
            key_reg <= reg_key;
            flags_reg <= ban_flags;
            why_reg <= reason;
            pen_reg <= pen_calc;
            miss_reg <= (opcode == OP_LOOKUP_IP) ? (ip_address == 32'd0)
                      : (reg_key == 32'd0 || reg_key == default_counter_reg);
        end
        if (better)
        begin
            best_idx_reg <= eval_idx_reg;
            best_age_reg <= ev.age;
            best_row_reg <= rd_data;
            best_rem_reg <= ev.remaining;
        end
        if (eval_v_reg && !row_valid && !free_found_reg)
        begin
            free_idx_reg <= eval_idx_reg;
        end
        eval_idx_reg <= scan_reg[IDX_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            default_counter_reg <= 32'd0;
            stamp_reg <= 32'd0;
            valid_reg <= '0;
            scan_reg <= '0;
            eval_v_reg <= 1'b0;
            best_found_reg <= 1'b0;
            free_found_reg <= 1'b0;
            count_reg <= 7'd0;
            out_valid <= 1'b0;
            hit <= 1'b0;
            hit_index <= 6'd0;
            hit_reason <= 4'd0;
            hit_flags <= 4'd0;
            hit_ip <= 32'd0;
            hit_key <= 32'd0;
            hit_remaining <= 31'd0;
            purged_count <= 7'd0;
            updated <= 1'b0;
            dropped <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                default_counter_reg <= cfg_wdata;
            end
            if (out_valid && out_ready && state_reg != S_DONE)
            begin
                out_valid <= 1'b0;
            end
            eval_v_reg <= issue;
            unique case (state_reg)
                S_IDLE:
                begin
                    scan_reg <= '0;
                    best_found_reg <= 1'b0;
                    free_found_reg <= 1'b0;
                    count_reg <= 7'd0;
                    if (in_valid)
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (issue)
                    begin
                        scan_reg <= scan_reg + CNT_W'(1);
                    end
                    if (better)
                    begin
                        best_found_reg <= 1'b1;
                    end
                    if (eval_v_reg && !row_valid)
                    begin
                        free_found_reg <= 1'b1;
                    end
                    if (eval_v_reg && op_reg == OP_PURGE && row_valid && ev.expired)
                    begin
                        valid_reg[eval_idx_reg] <= 1'b0;
                        count_reg <= count_reg + 7'd1;
                    end
                    if (eval_v_reg && eval_idx_reg == IDX_W'(ENTRIES - 1))
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (op_reg == OP_INSERT && !best_found_reg && free_found_reg)
                    begin
                        valid_reg[free_idx_reg] <= 1'b1;
                        stamp_reg <= stamp_reg + 32'd1;
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid || out_ready)
                    begin
                        out_valid <= 1'b1;
                        hit <= show_row;
                        hit_index <= hit_index_next;
                        hit_reason <= show_row ? best_row_reg.why : 4'd0;
                        hit_flags <= show_row ? best_row_reg.flags : 4'd0;
                        hit_ip <= show_row ? best_row_reg.address : 32'd0;
                        hit_key <= show_row ? best_row_reg.key : 32'd0;
                        hit_remaining <= show_row ? best_rem_reg : 31'd0;
                        purged_count <= (op_reg == OP_PURGE) ? count_reg : 7'd0;
                        updated <= (op_reg == OP_INSERT) && best_found_reg;
                        dropped <= (op_reg == OP_INSERT) && !best_found_reg
                                && !free_found_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ipban_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ipban_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        hit,
    input wire logic [6:0]  purged_count,
    input wire logic        updated,
    input wire logic        dropped
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before transfer");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while one is in work");

    a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && dropped |-> !updated && !hit)
        else $error("dropped insert reports other outcome");

    a_hit_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !updated && !dropped && purged_count == 7'd0)
        else $error("lookup hit mixed with other outcome");

endmodule

bind expiring_ip_ban_table_unit ipban_checker u_ipban_checker (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .hit(hit),
    .purged_count(purged_count),
    .updated(updated),
    .dropped(dropped)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import ipban_pkg::*;

    typedef struct {
        logic [2:0]  op;
        logic [30:0] now;
        logic [31:0] ip;
        logic [31:0] key;
        logic [3:0]  flags;
        logic [26:0] pm;
        logic [3:0]  why;
    } request_t;

    typedef struct {
        logic        hit;
        logic [5:0]  index;
        logic [3:0]  why;
        logic [3:0]  flags;
        logic [31:0] ip;
        logic [31:0] key;
        logic [30:0] remaining;
        logic [6:0]  purged;
        logic        updated;
        logic        dropped;
    } verdict_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  opcode;
    logic [30:0] now;
    logic [31:0] ip_address;
    logic [31:0] reg_key;
    logic [3:0]  ban_flags;
    logic [26:0] penalty_minutes;
    logic [3:0]  reason;
    logic        out_valid;
    logic        out_ready;
    logic        hit;
    logic [5:0]  hit_index;
    logic [3:0]  hit_reason;
    logic [3:0]  hit_flags;
    logic [31:0] hit_ip;
    logic [31:0] hit_key;
    logic [30:0] hit_remaining;
    logic [6:0]  purged_count;
    logic        updated;
    logic        dropped;

    expiring_ip_ban_table_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .now(now),
        .ip_address(ip_address), .reg_key(reg_key), .ban_flags(ban_flags),
        .penalty_minutes(penalty_minutes), .reason(reason),
        .out_valid(out_valid), .out_ready(out_ready), .hit(hit),
        .hit_index(hit_index), .hit_reason(hit_reason), .hit_flags(hit_flags),
        .hit_ip(hit_ip), .hit_key(hit_key), .hit_remaining(hit_remaining),
        .purged_count(purged_count), .updated(updated), .dropped(dropped)
    );

    logic        ban_live [ENTRIES];
    logic [3:0]  ban_flag [ENTRIES];
    logic [31:0] ban_addr [ENTRIES];
    logic [31:0] ban_key [ENTRIES];
    logic [30:0] ban_start [ENTRIES];
    logic [30:0] ban_pen [ENTRIES];
    logic [3:0]  ban_why [ENTRIES];
    logic [31:0] ban_stamp [ENTRIES];
    logic [31:0] next_stamp;
    logic [31:0] model_default;

    request_t pending_requests[$];
    verdict_t expected_verdicts[$];
    int  errors;
    bit  quiet_phase;
    bit  stimulus_done;

    function automatic longint seconds_left(int i, logic [30:0] t);
        return longint'(ban_pen[i]) - (longint'(t) - longint'(ban_start[i]));
    endfunction

    function automatic bit lookup_match(request_t r, int i);
        logic [3:0] f;
        f = ban_flag[i];
        if (!ban_live[i] || f[0] != r.flags[0] || seconds_left(i, r.now) <= 0)
            return 0;
        if (r.op == OP_LOOKUP_IP)
        begin
            if (f[1])
                return (r.ip & MASK24) == (ban_addr[i] & MASK24);
            if (f[2])
                return (r.ip & MASK16) == (ban_addr[i] & MASK16);
            return r.ip == ban_addr[i] && (ban_key[i] == 0 || ban_key[i] == model_default);
        end
        if (r.op == OP_LOOKUP_KEY)
            return !f[3] && r.key == ban_key[i];
        return f[3] && r.key == ban_key[i];
    endfunction

    function automatic verdict_t apply_request(request_t r);
        verdict_t v;
        int best;
        int i;
        logic [31:0] best_age;
        logic [31:0] age;
        logic [30:0] pen;
        longint rem;
        longint secs;
        v = '{default: '0};
        best = -1;
        best_age = 0;
        if (r.op == OP_INSERT)
        begin
            secs = longint'(r.pm) * 60;
            if (r.pm[26])
                pen = PERMANENT;
            else
                pen = (secs > longint'(PERMANENT)) ? PERMANENT : secs[30:0];
            for (i = 0; i < ENTRIES; i++)
            begin
                if (ban_live[i] && ban_flag[i] == r.flags && ban_addr[i] == r.ip
                    && ban_key[i] == r.key)
                begin
                    age = next_stamp - ban_stamp[i];
                    if (best < 0 || age < best_age)
                    begin
                        best = i;
                        best_age = age;
                    end
                end
            end
            if (best >= 0)
            begin
                ban_start[best] = r.now;
                ban_pen[best] = pen;
                ban_why[best] = r.why;
                v.index = best[5:0];
                v.updated = 1;
                return v;
            end
            for (i = 0; i < ENTRIES; i++)
                if (!ban_live[i])
                    break;
            if (i >= ENTRIES)
            begin
                v.dropped = 1;
                return v;
            end
            ban_live[i] = 1;
            ban_flag[i] = r.flags;
            ban_addr[i] = r.ip;
            ban_key[i] = r.key;
            ban_start[i] = r.now;
            ban_pen[i] = pen;
            ban_why[i] = r.why;
            ban_stamp[i] = next_stamp;
            next_stamp++;
            v.index = i[5:0];
            return v;
        end
        if (r.op == OP_PURGE)
        begin
            for (i = 0; i < ENTRIES; i++)
            begin
                if (ban_live[i] && seconds_left(i, r.now) <= 0)
                begin
                    ban_live[i] = 0;
                    v.purged++;
                end
            end
            return v;
        end
        if (r.op > OP_PURGE)
            return v;
        if (r.op == OP_LOOKUP_IP && r.ip == 0)
            return v;
        if (r.op != OP_LOOKUP_IP && (r.key == 0 || r.key == model_default))
            return v;
        for (i = 0; i < ENTRIES; i++)
        begin
            if (lookup_match(r, i))
            begin
                age = next_stamp - ban_stamp[i];
                if (best < 0 || age < best_age)
                begin
                    best = i;
                    best_age = age;
                end
            end
        end
        if (best >= 0)
        begin
            rem = seconds_left(best, r.now);
            if (rem > longint'(PERMANENT))
                rem = PERMANENT;
            v.hit = 1;
            v.index = best[5:0];
            v.why = ban_why[best];
            v.flags = ban_flag[best];
            v.ip = ban_addr[best];
            v.key = ban_key[best];
            v.remaining = rem[30:0];
        end
        return v;
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (quiet_phase)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(99) >= 20);
    end

    always @(posedge clk)
    begin
        if (!in_valid || in_ready)
        begin
            if (pending_requests.size() > 0 && (quiet_phase || $urandom_range(99) >= 20))
            begin
                request_t r;
                r = pending_requests.pop_front();
                expected_verdicts.push_back(apply_request(r));
                in_valid <= 1'b1;
                opcode <= r.op;
                now <= r.now;
                ip_address <= r.ip;
                reg_key <= r.key;
                ban_flags <= r.flags;
                penalty_minutes <= r.pm;
                reason <= r.why;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            verdict_t e;
            verdict_t a;
            a = '{hit, hit_index, hit_reason, hit_flags, hit_ip, hit_key, hit_remaining,
                  purged_count, updated, dropped};
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t unexpected result transfer, actual %p", $time, a);
                errors++;
            end
            else
            begin
                e = expected_verdicts.pop_front();
                if (a !== e)
                begin
                    $display("%0t mismatch expected %p actual %p", $time, e, a);
                    errors++;
                end
            end
        end
    end

    task automatic queue_request(logic [2:0] op, logic [30:0] t, logic [31:0] ip,
                                 logic [31:0] key, logic [3:0] flags, logic [26:0] pm,
                                 logic [3:0] why);
        request_t r;
        r = '{op, t, ip, key, flags, pm, why};
        pending_requests.push_back(r);
    endtask

    task automatic drain_and_write(logic [31:0] value);
        while (pending_requests.size() > 0 || expected_verdicts.size() > 0 || in_valid)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        model_default = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    logic [31:0] addr_pool [8];
    logic [31:0] key_pool [8];
    logic [30:0] clock_s;

    task automatic random_phase(int count);
        int k;
        logic [2:0] op;
        logic [31:0] ip;
        logic [31:0] key;
        logic [26:0] pm;
        for (k = 0; k < count; k++)
        begin
            clock_s = clock_s + 31'($urandom_range(120));
            if ($urandom_range(99) < 3)
                clock_s = clock_s + 31'($urandom_range(100000));
            if ($urandom_range(99) < 1)
                clock_s = 31'h7FFF0000 + 31'($urandom_range(60000));
            case ($urandom_range(9))
                0, 1, 2, 3: op = OP_INSERT;
                4, 5: op = OP_LOOKUP_IP;
                6: op = OP_LOOKUP_KEY;
                7: op = OP_LOOKUP_ID;
                8: op = ($urandom_range(3) == 0) ? 3'(5 + $urandom_range(2)) : OP_PURGE;
                default: op = OP_PURGE;
            endcase
            ip = addr_pool[$urandom_range(7)];
            if ($urandom_range(3) == 0)
                ip[7:0] = 8'($urandom);
            if ($urandom_range(9) == 0)
                ip = $urandom;
            key = key_pool[$urandom_range(7)];
            if ($urandom_range(9) == 0)
                key = $urandom;
            case ($urandom_range(9))
                0: pm = 27'h7FFFFFF - 27'($urandom_range(3));
                1: pm = 27'd35791394 + 27'($urandom_range(8));
                2: pm = 27'($urandom);
                default: pm = 27'($urandom_range(30));
            endcase
            queue_request(op, clock_s, ip, key, 4'($urandom), pm, 4'($urandom));
        end
    endtask

    initial
    begin
        int p;
        int j;
        errors = 0;
        quiet_phase = 0;
        stimulus_done = 0;
        rst_n = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        in_valid = 0;
        out_ready = 0;
        opcode = 0;
        now = 0;
        ip_address = 0;
        reg_key = 0;
        ban_flags = 0;
        penalty_minutes = 0;
        reason = 0;
        for (j = 0; j < ENTRIES; j++)
        begin
            ban_live[j] = 0;
            ban_stamp[j] = 0;
        end
        next_stamp = 0;
        model_default = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        queue_request(OP_INSERT, 100, 32'hC0A80105, 0, 4'h0, 5, 4'hF);
        queue_request(OP_INSERT, 100, 32'h0A000001, 0, 4'h2, 27'h7FFFFFF, 4'h1);
        queue_request(OP_INSERT, 100, 32'hAC100000, 0, 4'h4, 27'd35791394, 4'h2);
        queue_request(OP_INSERT, 100, 32'hFFFFFFFF, 32'hFFFFFFFF, 4'h9, 1, 4'h3);
        queue_request(OP_INSERT, 100, 32'h01020304, 32'h12345678, 4'h1, 0, 4'h4);
        queue_request(OP_INSERT, 110, 32'hC0A80105, 0, 4'h0, 10, 4'h5);
        queue_request(OP_LOOKUP_IP, 120, 32'hC0A80105, 0, 4'h0, 0, 0);
        queue_request(OP_LOOKUP_IP, 120, 32'h0A0000FE, 0, 4'h0, 0, 0);
        queue_request(OP_LOOKUP_IP, 120, 32'hAC10FFFF, 0, 4'h0, 0, 0);
        queue_request(OP_LOOKUP_IP, 120, 32'h0, 0, 4'h0, 0, 0);
        queue_request(OP_LOOKUP_IP, 120, 32'h01020304, 0, 4'h1, 0, 0);
        queue_request(OP_LOOKUP_ID, 120, 0, 32'hFFFFFFFF, 4'h1, 0, 0);
        queue_request(OP_LOOKUP_KEY, 120, 0, 32'h12345678, 4'h1, 0, 0);
        queue_request(OP_LOOKUP_KEY, 120, 0, 32'h0, 4'h0, 0, 0);
        queue_request(3'd7, 120, 32'hFFFFFFFF, 1, 4'hF, 27'h7FFFFFF, 4'hF);
        queue_request(OP_PURGE, 500, 0, 0, 0, 0, 0);
        queue_request(OP_PURGE, 31'h7FFFFFFF, 0, 0, 0, 0, 0);
        for (j = 0; j < 66; j++)
            queue_request(OP_INSERT, 5, j, j, 4'h0, 27'h7FFFFFF, 4'(j));
        queue_request(OP_PURGE, 31'h7FFFFFFF, 0, 0, 0, 0, 0);

        clock_s = 1000;
        for (p = 0; p < 6; p++)
        begin
            for (j = 0; j < 8; j++)
            begin
                addr_pool[j] = $urandom;
                key_pool[j] = (j < 2) ? j : $urandom;
            end
            case (p)
                0: drain_and_write(32'hFFFFFFFF);
                1: drain_and_write(key_pool[2]);
                2: drain_and_write(32'h0);
                default: drain_and_write($urandom);
            endcase
            quiet_phase = (p == 3);
            random_phase(300);
            queue_request(OP_PURGE, 31'h7FFFFFFF, 0, 0, 0, 0, 0);
        end
        while (pending_requests.size() > 0 || expected_verdicts.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_verdicts.size() == 0)
            $display("PASS expiring_ip_ban_table_unit");
        else
            $display("FAIL expiring_ip_ban_table_unit");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("FAIL expiring_ip_ban_table_unit");
        $finish;
    end
endmodule

// ===== expiring_ip_ban_table_unit.f =====
rtl/core/ipban_pkg.sv
rtl/core/ipban_eval.sv
rtl/core/expiring_ip_ban_table_unit.sv
rtl/core/ipban_checker.sv
tb/sv/tb.sv
